FILE: rtl/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Shared constants for the first-fit heap allocator: default sizes, request
// kinds and status codes.
// ============================================================================
package ffha_pkg;

    // Default geometry of the block table and the heap.
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 32;
    localparam int DEF_ALIGN_BYTES  = 16;   // must be a power of two
    localparam int DEF_ADDR_BITS    = 24;

    // A block is split only when the surplus exceeds one header plus this.
    localparam int SPLIT_SLACK = 16;

    // Heap size after reset and the smallest heap that may be configured.
    localparam int HEAP_RESET = 1048576;
    localparam int HEAP_MIN   = 64;

    // Request kinds.
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NULL   = 3'd1;
    localparam logic [2:0] ST_OOM    = 3'd2;
    localparam logic [2:0] ST_DOUBLE = 3'd3;
    localparam logic [2:0] ST_BADPTR = 3'd4;

endpackage

FILE: rtl/ffha_table.sv
// ============================================================================
// ffha_table
// Block table memory: one write port and one read port with registered
// read data.
// ============================================================================
module ffha_table #(
    parameter int DEPTH = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int WIDTH = 2 * ffha_pkg::DEF_ADDR_BITS + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read before write, read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ffha_seq.sv
// ============================================================================
// ffha_seq
// Request sequencer: walks the block table to search, shift, split, mark and
// coalesce entries, and keeps the block, byte and allocation counts.
// ============================================================================
module ffha_seq #(
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES,
    parameter int ADDR_BITS    = ffha_pkg::DEF_ADDR_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ADDR_BITS:0]                 heap,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         req_type,
    input  logic [ADDR_BITS-1:0]               req_bytes,
    input  logic [ADDR_BITS-1:0]               user_offset,
    input  logic                               out_busy,
    output logic                               done,
    output logic [2:0]                         res_status,
    output logic [ADDR_BITS-1:0]               res_offset,
    output logic [ADDR_BITS:0]                 res_copy,
    output logic [ADDR_BITS:0]                 res_used,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]    res_live,
    output logic                               mem_we,
    output logic [$clog2(MAX_BLOCKS)-1:0]      mem_waddr,
    output logic [2*ADDR_BITS:0]               mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(MAX_BLOCKS)-1:0]      mem_raddr,
    input  logic [2*ADDR_BITS:0]               mem_rdata
);

    localparam int AW = ADDR_BITS;
    localparam int IB = $clog2(MAX_BLOCKS);
    localparam int CB = $clog2(MAX_BLOCKS + 1);
    localparam logic [AW:0]   HDR    = (AW+1)'(HEADER_BYTES);
    localparam logic [AW+1:0] HDR2   = (AW+2)'(HEADER_BYTES);
    localparam logic [AW+1:0] SLACK2 = (AW+2)'(ffha_pkg::SPLIT_SLACK);
    localparam logic [AW:0]   ALIGN_M1 = (AW+1)'(ALIGN_BYTES - 1);
    localparam logic [CB-1:0] MAXC   = CB'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_SHIFT, S_SPLIT_HI, S_TAKE, S_FREE, S_COAL, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        type_reg, type_next;
    logic [AW-1:0]     bytes_reg, bytes_next;
    logic [AW-1:0]     off_reg, off_next;
    logic [AW:0]       need_reg, need_next;
    logic [CB-1:0]     count_reg, count_next;
    logic [AW:0]       used_reg, used_next;
    logic [CB-1:0]     alloc_reg, alloc_next;
    logic [CB-1:0]     ptr_reg, ptr_next;
    logic              pv_reg, pv_next;
    logic [IB-1:0]     pidx_reg, pidx_next;
    logic [IB-1:0]     hit_idx_reg, hit_idx_next;
    logic [AW-1:0]     hit_start_reg, hit_start_next;
    logic [AW-1:0]     hit_size_reg, hit_size_next;
    logic              hit_used_reg, hit_used_next;
    logic              hv_reg, hv_next;
    logic [IB-1:0]     w_reg, w_next;
    logic              fit_reg, fit_next;
    logic              mv_reg, mv_next;
    logic              split_reg, split_next;
    logic [2:0]        st_reg, st_next;
    logic [AW-1:0]     res_reg, res_next;
    logic [AW:0]       copy_reg, copy_next;

    // Fields of the entry being read.
    logic [AW-1:0]     rd_start, rd_size;
    logic              rd_used;
    logic [AW:0]       rd_user, bytes_pad, heap_free, hit_user, size_new_hdr;
    logic [AW:0]       hit_size_hdr, lo_start, lo_size, merged;
    logic [AW+1:0]     split_lim;
    logic              user_hit, fit_hit, split_ok, sh_issue;
    logic [CB-1:0]     idx_plus, ptr_dec;
    logic [AW-1:0]     size_new;

    assign rd_start = mem_rdata[AW-1:0];
    assign rd_size  = mem_rdata[2*AW-1:AW];
    assign rd_used  = mem_rdata[2*AW];

    // Comparisons and sums used by the walk.
    always_comb
    begin
        rd_user      = {1'b0, rd_start} + HDR;
        user_hit     = (rd_user == {1'b0, off_reg});
        fit_hit      = !rd_used && ({1'b0, rd_size} >= need_reg);
        split_lim    = {1'b0, need_reg} + HDR2 + SLACK2;
        split_ok     = ({2'b0, rd_size} > split_lim) && (count_reg < MAXC);
        bytes_pad    = {1'b0, req_bytes} + ALIGN_M1;
        heap_free    = heap - HDR;
        hit_user     = {1'b0, hit_start_reg} + HDR;
        hit_size_hdr = {1'b0, hit_size_reg} + HDR;
        size_new     = split_reg ? need_reg[AW-1:0] : hit_size_reg;
        size_new_hdr = {1'b0, size_new} + HDR;
        lo_start     = hit_user + need_reg;
        lo_size      = {1'b0, hit_size_reg} - need_reg - HDR;
        merged       = {1'b0, hit_size_reg} + {1'b0, rd_size} + HDR;
        idx_plus     = CB'(hit_idx_reg) + CB'(1);
        ptr_dec      = ptr_reg - CB'(1);
        sh_issue     = (ptr_reg > idx_plus);
    end

    // Next-state logic and table commands.
    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        bytes_next     = bytes_reg;
        off_next       = off_reg;
        need_next      = need_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        alloc_next     = alloc_reg;
        ptr_next       = ptr_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_start_next = hit_start_reg;
        hit_size_next  = hit_size_reg;
        hit_used_next  = hit_used_reg;
        hv_next        = hv_reg;
        w_next         = w_reg;
        fit_next       = fit_reg;
        mv_next        = mv_reg;
        split_next     = split_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        copy_next      = copy_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg[IB-1:0];
        done           = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                // Table becomes one free block covering the heap.
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {1'b0, heap_free[AW-1:0], {AW{1'b0}}};
                count_next = CB'(1);
                used_next  = HDR;
                alloc_next = '0;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    type_next  = req_type;
                    bytes_next = req_bytes;
                    off_next   = user_offset;
                    need_next  = bytes_pad & ~ALIGN_M1;
                    st_next    = ffha_pkg::ST_OK;
                    res_next   = '0;
                    copy_next  = '0;
                    mv_next    = 1'b0;
                    ptr_next   = '0;
                    pv_next    = 1'b0;
                    case (req_type) inside
                        ffha_pkg::REQ_ALLOC, ffha_pkg::REQ_REALLOC:
                        begin
                            if (req_type == ffha_pkg::REQ_REALLOC && user_offset != '0)
                            begin
                                fit_next   = 1'b0;
                                state_next = S_SCAN;
                            end
                            else if (req_bytes == '0)
                            begin
                                st_next    = ffha_pkg::ST_NULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                fit_next   = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        ffha_pkg::REQ_FREE:
                        begin
                            fit_next   = 1'b0;
                            state_next = (user_offset == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads run one entry ahead of the compare.
                mem_re = (ptr_reg < count_reg);
                if (mem_re)
                begin
                    ptr_next  = ptr_reg + CB'(1);
                    pidx_next = ptr_reg[IB-1:0];
                end
                pv_next = mem_re;
                if (pv_reg && (fit_reg ? fit_hit : user_hit))
                begin
                    hit_idx_next   = pidx_reg;
                    hit_start_next = rd_start;
                    hit_size_next  = rd_size;
                    hit_used_next  = rd_used;
                    pv_next        = 1'b0;
                    if (fit_reg)
                    begin
                        split_next = split_ok;
                        ptr_next   = count_reg;
                        state_next = split_ok ? S_SHIFT : S_TAKE;
                    end
                    else if (mv_reg)
                    begin
                        state_next = S_FREE;
                    end
                    else if (!rd_used)
                    begin
                        st_next    = ffha_pkg::ST_DOUBLE;
                        state_next = S_DONE;
                    end
                    else if (type_reg == ffha_pkg::REQ_FREE)
                    begin
                        state_next = S_FREE;
                    end
                    else if (bytes_reg == '0)
                    begin
                        st_next    = ffha_pkg::ST_NULL;
                        state_next = S_FREE;
                    end
                    else if (rd_size >= bytes_reg)
                    begin
                        res_next   = off_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Block must move: find room for the new one first.
                        copy_next  = {1'b0, rd_size};
                        fit_next   = 1'b1;
                        ptr_next   = '0;
                    end
                end
                else if (!pv_reg && ptr_reg >= count_reg)
                begin
                    st_next    = fit_reg ? ffha_pkg::ST_OOM : ffha_pkg::ST_BADPTR;
                    res_next   = '0;
                    copy_next  = '0;
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // Move entries above the split point up by one, top first.
                mem_re    = sh_issue;
                mem_raddr = ptr_dec[IB-1:0];
                if (sh_issue)
                begin
                    ptr_next  = ptr_dec;
                    pidx_next = ptr_reg[IB-1:0];
                end
                pv_next = sh_issue;
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pidx_reg;
                    mem_wdata = mem_rdata;
                end
                if (!sh_issue && !pv_reg)
                begin
                    state_next = S_SPLIT_HI;
                end
            end

            S_SPLIT_HI:
            begin
                // Free remainder of the split block.
                mem_we     = 1'b1;
                mem_waddr  = idx_plus[IB-1:0];
                mem_wdata  = {1'b0, lo_size[AW-1:0], lo_start[AW-1:0]};
                count_next = count_reg + CB'(1);
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hit_idx_reg;
                mem_wdata  = {1'b1, size_new, hit_start_reg};
                used_next  = used_reg + size_new_hdr;
                alloc_next = alloc_reg + CB'(1);
                res_next   = hit_user[AW-1:0];
                if (type_reg == ffha_pkg::REQ_REALLOC && off_reg != '0)
                begin
                    // Now release the old block.
                    mv_next    = 1'b1;
                    fit_next   = 1'b0;
                    ptr_next   = '0;
                    pv_next    = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FREE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hit_idx_reg;
                mem_wdata  = {1'b0, hit_size_reg, hit_start_reg};
                used_next  = used_reg - hit_size_hdr;
                alloc_next = alloc_reg - CB'(1);
                ptr_next   = '0;
                pv_next    = 1'b0;
                hv_next    = 1'b0;
                w_next     = '0;
                state_next = S_COAL;
            end

            S_COAL:
            begin
                // Stream the table through a held entry, merging free runs.
                mem_re = (ptr_reg < count_reg);
                if (mem_re)
                begin
                    ptr_next = ptr_reg + CB'(1);
                end
                pv_next = mem_re;
                if (pv_reg)
                begin
                    if (!hv_reg)
                    begin
                        hv_next        = 1'b1;
                        hit_start_next = rd_start;
                        hit_size_next  = rd_size;
                        hit_used_next  = rd_used;
                    end
                    else if (!hit_used_reg && !rd_used)
                    begin
                        hit_size_next = merged[AW-1:0];
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = w_reg;
                        mem_wdata      = {hit_used_reg, hit_size_reg, hit_start_reg};
                        w_next         = w_reg + IB'(1);
                        hit_start_next = rd_start;
                        hit_size_next  = rd_size;
                        hit_used_next  = rd_used;
                    end
                end
                else if (ptr_reg >= count_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = w_reg;
                    mem_wdata  = {hit_used_reg, hit_size_reg, hit_start_reg};
                    count_next = CB'(w_reg) + CB'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_busy)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // A heap size write rebuilds the table.
        if (cfg_we)
        begin
            state_next = S_INIT;
        end
    end

    // State and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= CB'(1);
            used_reg  <= HDR;
            alloc_reg <= '0;
            ptr_reg   <= '0;
            pv_reg    <= 1'b0;
            hv_reg    <= 1'b0;
            fit_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            split_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            alloc_reg <= alloc_next;
            ptr_reg   <= ptr_next;
            pv_reg    <= pv_next;
            hv_reg    <= hv_next;
            fit_reg   <= fit_next;
            mv_reg    <= mv_next;
            split_reg <= split_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        bytes_reg     <= bytes_next;
        off_reg       <= off_next;
        need_reg      <= need_next;
        pidx_reg      <= pidx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        hit_size_reg  <= hit_size_next;
        hit_used_reg  <= hit_used_next;
        w_reg         <= w_next;
        st_reg        <= st_next;
        res_reg       <= res_next;
        copy_reg      <= copy_next;
    end

    assign res_status = st_reg;
    assign res_offset = res_reg;
    assign res_copy   = copy_reg;
    assign res_used   = used_reg;
    assign res_live   = alloc_reg;

    // The table always holds at least one block and never overflows.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= MAXC))
        else $error("block count out of range");

    // Live allocations can never exceed the number of blocks while idle.
    a_alloc_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (alloc_reg <= count_reg))
        else $error("more live allocations than blocks");

    // A result is only handed over when the output stage has room.
    a_done_room: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !out_busy)
        else $error("result handed over to a busy output stage");

    // Reads and writes in one cycle never touch the same entry.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same table entry");

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// ============================================================================
// first_fit_heap_allocator
// First-fit heap allocator over an address-ordered block table held in a
// synchronous memory; serves allocate, free and reallocate requests.
// ============================================================================
//
//  Channel   Signals                                      Direction
//  -------   ------------------------------------------   ---------
//  in        in_valid/in_ready, req_type, req_bytes,      item in
//            user_offset
//  out       out_valid/out_ready, status, result_offset,  item out
//            copy_bytes, used_bytes, live_allocations
//  cfg       cfg_wr_en, cfg_wr_data (heap size)           write only
//
//  An item takes one table walk per pass: a search walks the table, a split
//  adds a shift of the entries above the split point, and a free adds a
//  coalescing walk. The worst case is a moving reallocate: two searches for
//  the old block, one for room, a shift and a coalescing walk; the single
//  table read port sets the length of each walk.
//  After reset and after a heap size write the table is rebuilt in the init
//  state, during which no item is accepted.
//  The result goes to an output register; while that register still holds
//  an untaken item the next result waits, and while it waits no new item is accepted.
//
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES,
    parameter int ADDR_BITS    = ffha_pkg::DEF_ADDR_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ADDR_BITS:0]              cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [ADDR_BITS-1:0]            req_bytes,
    input  logic [ADDR_BITS-1:0]            user_offset,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [ADDR_BITS-1:0]            result_offset,
    output logic [ADDR_BITS:0]              copy_bytes,
    output logic [ADDR_BITS:0]              used_bytes,
    output logic [$clog2(MAX_BLOCKS+1)-1:0] live_allocations
);

    localparam int AW = ADDR_BITS;
    localparam int IB = $clog2(MAX_BLOCKS);
    localparam int CB = $clog2(MAX_BLOCKS + 1);
    localparam logic [AW:0] HEAP_TOP = (AW+1)'(1) << AW;
    localparam logic [AW:0] HEAP_LOW = (AW+1)'(ffha_pkg::HEAP_MIN);
    localparam logic [AW:0] HEAP_RST =
        ((64'(ffha_pkg::HEAP_RESET) >> AW) != 0) ? HEAP_TOP : (AW+1)'(ffha_pkg::HEAP_RESET);

    logic [AW:0]     heap_reg, heap_next;
    logic            out_valid_reg;
    logic [2:0]      status_reg;
    logic [AW-1:0]   result_reg;
    logic [AW:0]     copy_reg, used_reg;
    logic [CB-1:0]   live_reg;

    logic            out_busy, done;
    logic [2:0]      s_status;
    logic [AW-1:0]   s_offset;
    logic [AW:0]     s_copy, s_used;
    logic [CB-1:0]   s_live;
    logic            mem_we, mem_re;
    logic [IB-1:0]   mem_waddr, mem_raddr;
    logic [2*AW:0]   mem_wdata, mem_rdata;

    // Heap size clamped into the supported range.
    always_comb
    begin
        if (cfg_wr_data < HEAP_LOW)
        begin
            heap_next = HEAP_LOW;
        end
        else if (cfg_wr_data > HEAP_TOP)
        begin
            heap_next = HEAP_TOP;
        end
        else
        begin
            heap_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= HEAP_RST;
        end
        else if (cfg_wr_en)
        begin
            heap_reg <= heap_next;
        end
    end

    assign out_busy = out_valid_reg && !out_ready;

    ffha_seq #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_wr_en),
        .heap        (heap_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .req_bytes   (req_bytes),
        .user_offset (user_offset),
        .out_busy    (out_busy),
        .done        (done),
        .res_status  (s_status),
        .res_offset  (s_offset),
        .res_copy    (s_copy),
        .res_used    (s_used),
        .res_live    (s_live),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (2 * ADDR_BITS + 1)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: holds one result item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status_reg <= s_status;
            result_reg <= s_offset;
            copy_reg   <= s_copy;
            used_reg   <= s_used;
            live_reg   <= s_live;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign result_offset    = result_reg;
    assign copy_bytes       = copy_reg;
    assign used_bytes       = used_reg;
    assign live_allocations = live_reg;

endmodule

FILE: verif/first_fit_heap_allocator_test.sv
`timescale 1ns / 1ps
// ============================================================================
// first_fit_heap_allocator_test
// Drives allocate, free and reallocate items into the heap allocator under
// random idling on both sides and checks every result against a predictor of
// the block table kept inside this module.
// ============================================================================
module first_fit_heap_allocator_test;

    localparam int NBLK   = ffha_pkg::DEF_MAX_BLOCKS;
    localparam int HDR    = ffha_pkg::DEF_HEADER_BYTES;
    localparam int ALN    = ffha_pkg::DEF_ALIGN_BYTES;
    localparam int ABITS  = ffha_pkg::DEF_ADDR_BITS;
    localparam int WDOG   = 20000;
    localparam int SETTLE = 4 * NBLK + 40;
    localparam int NRAND  = 400;

    typedef struct packed {
        logic [2:0]       status;
        logic [ABITS-1:0] result_offset;
        logic [ABITS:0]   copy_bytes;
        logic [ABITS:0]   used_bytes;
        logic [6:0]       live_allocations;
    } outcome_t;

    typedef struct {
        logic [1:0]       kind;
        logic [ABITS-1:0] bytes;
        logic [ABITS-1:0] uoff;
        bit               typed;
        outcome_t         want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [ABITS:0]    cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        req_type = '0;
    logic [ABITS-1:0]  req_bytes = '0;
    logic [ABITS-1:0]  user_offset = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        status;
    logic [ABITS-1:0]  result_offset;
    logic [ABITS:0]    copy_bytes;
    logic [ABITS:0]    used_bytes;
    logic [6:0]        live_allocations;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .req_bytes(req_bytes), .user_offset(user_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_offset(result_offset),
        .copy_bytes(copy_bytes), .used_bytes(used_bytes),
        .live_allocations(live_allocations)
    );

    always #1 clk = ~clk;

    // Predicted block table and counters.
    longint   blk_start [NBLK];
    longint   blk_size [NBLK];
    bit       blk_used [NBLK];
    int       blk_count;
    longint   used_sum;
    int       live_count;

    outcome_t pending_results[$];
    bit       failed = 1'b0;
    bit       no_idle = 1'b0;
    int       quiet_cycles = 0;
    int       out_hold = 0;

    function automatic void table_init(longint hb);
        for (int k = 0; k < NBLK; k++)
        begin
            blk_start[k] = 0;
            blk_size[k]  = 0;
            blk_used[k]  = 1'b0;
        end
        blk_count  = 1;
        blk_size[0] = hb - HDR;
        used_sum   = HDR;
        live_count = 0;
    endfunction

    function automatic int block_of(longint off);
        for (int k = 0; k < blk_count; k++)
            if (blk_start[k] + HDR == off)
                return k;
        return -1;
    endfunction

    function automatic logic [2:0] take_block(longint bytes, output longint res);
        longint need;
        int     k;
        res = 0;
        if (bytes == 0)
            return ffha_pkg::ST_NULL;
        need = ((bytes + ALN - 1) / ALN) * ALN;
        for (k = 0; k < blk_count; k++)
            if (!blk_used[k] && blk_size[k] >= need)
                break;
        if (k >= blk_count)
            return ffha_pkg::ST_OOM;
        if (blk_size[k] > need + HDR + ffha_pkg::SPLIT_SLACK && blk_count < NBLK)
        begin
            for (int j = blk_count; j > k + 1; j--)
            begin
                blk_start[j] = blk_start[j-1];
                blk_size[j]  = blk_size[j-1];
                blk_used[j]  = blk_used[j-1];
            end
            blk_start[k+1] = blk_start[k] + HDR + need;
            blk_size[k+1]  = blk_size[k] - need - HDR;
            blk_used[k+1]  = 1'b0;
            blk_size[k]    = need;
            blk_count++;
        end
        blk_used[k] = 1'b1;
        used_sum += blk_size[k] + HDR;
        live_count++;
        res = blk_start[k] + HDR;
        return ffha_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] release_block(longint off);
        int k;
        if (off == 0)
            return ffha_pkg::ST_OK;
        k = block_of(off);
        if (k < 0)
            return ffha_pkg::ST_BADPTR;
        if (!blk_used[k])
            return ffha_pkg::ST_DOUBLE;
        blk_used[k] = 1'b0;
        used_sum -= blk_size[k] + HDR;
        live_count--;
        // Merge every run of adjacent free blocks.
        k = 0;
        while (k + 1 < blk_count)
        begin
            if (!blk_used[k] && !blk_used[k+1])
            begin
                blk_size[k] += blk_size[k+1] + HDR;
                for (int j = k + 1; j + 1 < blk_count; j++)
                begin
                    blk_start[j] = blk_start[j+1];
                    blk_size[j]  = blk_size[j+1];
                    blk_used[j]  = blk_used[j+1];
                end
                blk_count--;
            end
            else
                k++;
        end
        return ffha_pkg::ST_OK;
    endfunction

    function automatic outcome_t heap_predict(logic [1:0] kind, longint bytes,
                                              longint off);
        outcome_t   o;
        logic [2:0] st;
        longint     res;
        longint     copy;
        longint     old_size;
        int         k;
        st = ffha_pkg::ST_OK; res = 0; copy = 0;
        if (kind == ffha_pkg::REQ_ALLOC)
            st = take_block(bytes, res);
        else if (kind == ffha_pkg::REQ_FREE)
            st = release_block(off);
        else if (kind == ffha_pkg::REQ_REALLOC)
        begin
            if (off == 0)
                st = take_block(bytes, res);
            else
            begin
                k = block_of(off);
                if (k < 0)
                    st = ffha_pkg::ST_BADPTR;
                else if (!blk_used[k])
                    st = ffha_pkg::ST_DOUBLE;
                else if (bytes == 0)
                begin
                    void'(release_block(off));
                    st = ffha_pkg::ST_NULL;
                end
                else if (blk_size[k] >= bytes)
                    res = off;
                else
                begin
                    old_size = blk_size[k];
                    st = take_block(bytes, res);
                    if (st == ffha_pkg::ST_OK)
                    begin
                        copy = old_size;
                        void'(release_block(off));
                    end
                end
            end
        end
        o.status           = st;
        o.result_offset    = res[ABITS-1:0];
        o.copy_bytes       = copy[ABITS:0];
        o.used_bytes       = used_sum[ABITS:0];
        o.live_allocations = live_count[6:0];
        return o;
    endfunction

    // Pick a user pointer: mostly a live block, sometimes any block, null or junk.
    function automatic logic [ABITS-1:0] pick_pointer();
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, blk_count - 1);
        if (r < 70)
        begin
            for (int t = 0; t < blk_count; t++)
                if (blk_used[(k + t) % blk_count])
                    return ABITS'(blk_start[(k + t) % blk_count] + HDR);
        end
        if (r < 85)
            return ABITS'(blk_start[k] + HDR);
        if (r < 90)
            return '0;
        return ABITS'($urandom);
    endfunction

    // Output side: random stall bursts, and the check of each item taken.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t exp_o;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, result_offset, copy_bytes, used_bytes, live_allocations};
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item, status %0d", status);
                failed = 1'b1;
            end
            else
            begin
                exp_o = pending_results.pop_front();
                if (got.status !== exp_o.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_o.status, got.status);
                    failed = 1'b1;
                end
                if (got.result_offset !== exp_o.result_offset)
                begin
                    $error("result_offset: expected %0d, actual %0d",
                           exp_o.result_offset, got.result_offset);
                    failed = 1'b1;
                end
                if (got.copy_bytes !== exp_o.copy_bytes)
                begin
                    $error("copy_bytes: expected %0d, actual %0d",
                           exp_o.copy_bytes, got.copy_bytes);
                    failed = 1'b1;
                end
                if (got.used_bytes !== exp_o.used_bytes)
                begin
                    $error("used_bytes: expected %0d, actual %0d",
                           exp_o.used_bytes, got.used_bytes);
                    failed = 1'b1;
                end
                if (got.live_allocations !== exp_o.live_allocations)
                begin
                    $error("live_allocations: expected %0d, actual %0d",
                           exp_o.live_allocations, got.live_allocations);
                    failed = 1'b1;
                end
            end
        end
        if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            out_hold <= $urandom_range(1, 11);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog on cycles with no item accepted on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one item, hold it until accepted, and record its prediction.
    // The block cannot take a new item in the cycle after an acceptance, so
    // valid is driven low after every item.
    task automatic send_item(logic [1:0] kind, logic [ABITS-1:0] bytes,
                             logic [ABITS-1:0] uoff, bit typed, outcome_t want);
        outcome_t p;
        int       gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        req_bytes   <= bytes;
        user_offset <= uoff;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = heap_predict(kind, bytes, uoff);
        if (typed && p !== want)
        begin
            $error("status: expected %0d, actual %0d (table row disagrees)",
                   want.status, p.status);
            failed = 1'b1;
        end
        pending_results.push_back(p);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_heap(logic [ABITS:0] hb);
        longint v;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hb;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        v = hb;
        if (v < ffha_pkg::HEAP_MIN)
            v = ffha_pkg::HEAP_MIN;
        if (v > (longint'(1) << ABITS))
            v = longint'(1) << ABITS;
        table_init(v);
    endtask

    task automatic random_phase(int count, int big_pct);
        int               r;
        logic [1:0]       kind;
        logic [ABITS-1:0] bytes;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                kind = ffha_pkg::REQ_ALLOC;
            else if (r < 75)
                kind = ffha_pkg::REQ_FREE;
            else if (r < 97)
                kind = ffha_pkg::REQ_REALLOC;
            else
                kind = 2'd3;
            r = $urandom_range(0, 99);
            if (r < big_pct)
                bytes = ABITS'($urandom);
            else if (r < 90)
                bytes = ABITS'($urandom_range(1, 4096));
            else
                bytes = ABITS'($urandom_range(0, 40));
            send_item(kind, bytes, pick_pointer(), 1'b0, '0);
            if (n == count / 2 && count > 20)
                drain_results();
        end
    endtask

    stim_row_t directed [] = '{
        // Zero-byte allocate yields null.
        '{ffha_pkg::REQ_ALLOC, 24'd0, 24'd0, 1'b1,
          '{ffha_pkg::ST_NULL, 24'd0, 25'd0, 25'd32, 7'd0}},
        // Largest request cannot fit.
        '{ffha_pkg::REQ_ALLOC, 24'hFFFFFF, 24'd0, 1'b1,
          '{ffha_pkg::ST_OOM, 24'd0, 25'd0, 25'd32, 7'd0}},
        // First block handed out from offset 0.
        '{ffha_pkg::REQ_ALLOC, 24'd1, 24'd0, 1'b1,
          '{ffha_pkg::ST_OK, 24'd32, 25'd0, 25'd80, 7'd1}},
        '{ffha_pkg::REQ_ALLOC, 24'd100, 24'd0, 1'b0, '0},
        '{ffha_pkg::REQ_ALLOC, 24'd16, 24'd0, 1'b0, '0},
        // Free of null is a no-op.
        '{ffha_pkg::REQ_FREE, 24'd0, 24'd0, 1'b0, '0},
        // Pointer that starts no block; three blocks are live at this point.
        '{ffha_pkg::REQ_FREE, 24'd0, 24'd33, 1'b1,
          '{ffha_pkg::ST_BADPTR, 24'd0, 25'd0, 25'd272, 7'd3}},
        '{ffha_pkg::REQ_FREE, 24'd0, 24'hFFFFFF, 1'b0, '0},
        '{ffha_pkg::REQ_FREE, 24'd0, 24'd32, 1'b0, '0},
        // Double free of the same pointer.
        '{ffha_pkg::REQ_FREE, 24'd0, 24'd32, 1'b0, '0},
        '{ffha_pkg::REQ_REALLOC, 24'd8, 24'd32, 1'b0, '0},
        // Reallocate of null behaves as allocate.
        '{ffha_pkg::REQ_REALLOC, 24'd40, 24'd0, 1'b0, '0},
        // Reallocate of a pointer that was already freed.
        '{ffha_pkg::REQ_REALLOC, 24'd10, 24'd32, 1'b0, '0},
        // Larger reallocate of the freed pointer.
        '{ffha_pkg::REQ_REALLOC, 24'd5000, 24'd32, 1'b0, '0},
        '{ffha_pkg::REQ_REALLOC, 24'hFFFFFF, 24'd96, 1'b0, '0},
        // Reallocate to zero of a pointer that starts no block.
        '{ffha_pkg::REQ_REALLOC, 24'd0, 24'd96, 1'b0, '0},
        '{ffha_pkg::REQ_REALLOC, 24'd7, 24'd12345, 1'b0, '0},
        // Unknown request kind.
        '{2'd3, 24'hAAAAAA, 24'h555555, 1'b0, '0},
        '{2'd3, 24'h555555, 24'hAAAAAA, 1'b0, '0}
    };

    initial
    begin
        logic [ABITS:0] hb;
        table_init(ffha_pkg::HEAP_RESET);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[k])
            send_item(directed[k].kind, directed[k].bytes, directed[k].uoff,
                      directed[k].typed, directed[k].want);
        drain_results();

        // Default heap, mixed sizes.
        random_phase(100, 3);
        drain_results();

        // Smallest heap: almost everything runs out of memory.
        write_heap('0);
        random_phase(30, 0);
        drain_results();

        // Small heap that fills the table and forces splits to be skipped.
        write_heap(25'd70000);
        for (int n = 0; n < 70; n++)
            send_item(ffha_pkg::REQ_ALLOC, ABITS'($urandom_range(1, 200)), '0, 1'b0, '0);
        random_phase(60, 2);
        drain_results();

        // Largest heap, beyond the top so it is clamped.
        write_heap('1);
        random_phase(60, 10);
        drain_results();

        // Random size, then the final stretch with no idling.
        hb = (ABITS+1)'($urandom_range(64, 1 << ABITS));
        write_heap(hb);
        random_phase(40, 5);
        no_idle = 1'b1;
        random_phase(40, 5);
        drain_results();

        if (!failed)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
